// ===== hw/rtl/vnz_pkg.sv =====
// ----------------------------------------------------------------------------
// vnz_pkg
// Types, widths and the quotient search step shared by the normalizer blocks.
// ----------------------------------------------------------------------------
package vnz_pkg;

  localparam int CompBits  = 16;
  localparam int Lanes     = 4;
  localparam int QuoBits   = CompBits - 1;
  localparam int SqBits    = 2 * CompBits;
  localparam int SumBits   = 2 * CompBits + 1;
  localparam int AccBits   = 4 * CompBits + 2;
  localparam int QueueDepth = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);

  typedef logic signed [CompBits-1:0] comp_t;
  typedef logic [SqBits-1:0]          sq_t;
  typedef logic [SumBits-1:0]         sum_t;
  typedef logic signed [AccBits-1:0]  acc_t;
  typedef logic [QuoBits-1:0]         quo_t;

  // One classified vector waiting for the quotient search.
  typedef struct packed {
    sq_t  [Lanes-1:0] sq;
    logic [Lanes-1:0] neg;
    sum_t             sum;
    logic             short_vec;
  } vnz_item_t;

  // Search state of one lane: acc_a = v*v*S, acc_b = v*S with v = 2q-1.
  typedef struct packed {
    acc_t acc_a;
    acc_t acc_b;
    quo_t quo;
  } vnz_lane_t;

  // Try setting bit b of the quotient: accept if (2t-1)^2 * S <= sq * 2^(2*CompBits).
  function automatic vnz_lane_t quo_step(vnz_lane_t cur, sum_t s, sq_t sq, int b);
    acc_t      cand;
    acc_t      lim;
    acc_t      s_ext;
    vnz_lane_t res;
    s_ext = acc_t'(s);
    cand  = cur.acc_a + (cur.acc_b <<< (b + 2)) + (s_ext <<< (2 * b + 2));
    lim   = acc_t'(sq) <<< (2 * CompBits);
    res   = cur;
    if ($unsigned(cand) <= $unsigned(lim)) begin
      res.acc_a = cand;
      res.acc_b = cur.acc_b + (s_ext <<< (b + 1));
      res.quo   = cur.quo | (quo_t'(1) << b);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/vnz_in_if.sv =====
// ----------------------------------------------------------------------------
// vnz_in_if
// Input channel: one four-component vector per beat.
// ----------------------------------------------------------------------------
interface vnz_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vnz_pkg::CompBits-1:0]  comp_x;
  logic signed [vnz_pkg::CompBits-1:0]  comp_y;
  logic signed [vnz_pkg::CompBits-1:0]  comp_z;
  logic signed [vnz_pkg::CompBits-1:0]  comp_w;

  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

// ===== hw/rtl/vnz_out_if.sv =====
// ----------------------------------------------------------------------------
// vnz_out_if
// Result channel: one normalized vector and its short flag per beat.
// ----------------------------------------------------------------------------
interface vnz_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vnz_pkg::CompBits-1:0]  unit_x;
  logic signed [vnz_pkg::CompBits-1:0]  unit_y;
  logic signed [vnz_pkg::CompBits-1:0]  unit_z;
  logic signed [vnz_pkg::CompBits-1:0]  unit_w;
  logic                                 too_short;

  modport source (output valid, unit_x, unit_y, unit_z, unit_w, too_short, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, too_short, output ready);
endinterface

// ===== hw/rtl/vnz_front.sv =====
// ----------------------------------------------------------------------------
// vnz_front
// Squares the components, sums the squared length and tests it against the
// threshold register.
// ----------------------------------------------------------------------------
module vnz_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vnz_pkg::SumBits-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vnz_pkg::comp_t [vnz_pkg::Lanes-1:0] in_comp,
  output logic                               item_valid,
  input  logic                               item_ready,
  output vnz_pkg::vnz_item_t                 item
);
  import vnz_pkg::*;

  sum_t             thr_r;
  logic             v1_r, v2_r;
  sq_t  [Lanes-1:0] sq_r;
  logic [Lanes-1:0] neg_r;
  vnz_item_t        item_r;
  logic             adv2, adv1;
  sum_t             sum_nxt;

  assign adv2     = !v2_r || item_ready;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < Lanes; i++) sum_nxt = sum_nxt + sum_t'(sq_r[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= sum_t'(10);
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < Lanes; i++) begin
        // The square of a signed value is never negative; at most 2^(2n-2).
        sq_r[i]  <= sq_t'(in_comp[i] * in_comp[i]);
        neg_r[i] <= in_comp[i][CompBits-1];
      end
    end
    if (adv2) begin
      item_r.sq        <= sq_r;
      item_r.neg       <= neg_r;
      item_r.sum       <= sum_nxt;
      item_r.short_vec <= (sum_nxt <= thr_r);
    end
  end

  assign item_valid = v2_r;
  assign item       = item_r;
endmodule

// ===== hw/rtl/vnz_queue.sv =====
// ----------------------------------------------------------------------------
// vnz_queue
// Short FIFO that decouples classification from the quotient search.
// ----------------------------------------------------------------------------
module vnz_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  vnz_pkg::vnz_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output vnz_pkg::vnz_item_t pop_item
);
  import vnz_pkg::*;

  vnz_item_t                 slot_r [QueueDepth];
  logic [QueuePtrBits-1:0]   wptr_r, rptr_r;
  logic [QueuePtrBits:0]     cnt_r;
  logic                      do_push, do_pop;

  assign push_ready = (cnt_r != (QueuePtrBits+1)'(QueueDepth));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wptr_r] <= push_item;
  end
endmodule

// ===== hw/rtl/vnz_back.sv =====
// ----------------------------------------------------------------------------
// vnz_back
// Pipelined bit-by-bit search for the rounded quotient, four lanes wide, one
// quotient bit per stage, ending in the output register.
// ----------------------------------------------------------------------------
module vnz_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  vnz_pkg::vnz_item_t                  item,
  output logic                                res_valid,
  input  logic                                res_ready,
  output vnz_pkg::comp_t [vnz_pkg::Lanes-1:0] res_unit,
  output logic                                res_short
);
  import vnz_pkg::*;

  localparam int Stages = QuoBits + 1;

  logic                         vld_r   [Stages];
  vnz_lane_t [Lanes-1:0]        lane_r  [Stages];
  sq_t       [Lanes-1:0]        sq_r    [Stages];
  logic      [Lanes-1:0]        neg_r   [Stages];
  sum_t                         sum_r   [Stages];
  logic                         short_r [Stages];
  logic                         en;

  // The whole pipe moves together whenever the last stage can drain.
  assign en         = !vld_r[Stages-1] || res_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Stages; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= item_valid;
      for (int k = 1; k < Stages; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Entry: q = 0 gives v = -1, so v*v*S = S and v*S = -S.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Lanes; i++) begin
        lane_r[0][i].acc_a <= acc_t'(item.sum);
        lane_r[0][i].acc_b <= -acc_t'(item.sum);
        lane_r[0][i].quo   <= '0;
      end
      sq_r[0]    <= item.sq;
      neg_r[0]   <= item.neg;
      sum_r[0]   <= item.sum;
      short_r[0] <= item.short_vec;
    end
  end

  for (genvar k = 0; k < QuoBits; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < Lanes; i++) begin
          lane_r[k+1][i] <= quo_step(lane_r[k][i], sum_r[k], sq_r[k][i], QuoBits - 1 - k);
        end
        sq_r[k+1]    <= sq_r[k];
        neg_r[k+1]   <= neg_r[k];
        sum_r[k+1]   <= sum_r[k];
        short_r[k+1] <= short_r[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      if (short_r[Stages-1]) begin
        res_unit[i] = '0;
      end else if (neg_r[Stages-1][i]) begin
        res_unit[i] = -comp_t'(lane_r[Stages-1][i].quo);
      end else begin
        res_unit[i] = comp_t'(lane_r[Stages-1][i].quo);
      end
    end
  end

  assign res_valid = vld_r[Stages-1];
  assign res_short = short_r[Stages-1];
endmodule

// ===== hw/rtl/vec4_normalise_or_zero.sv =====
// ----------------------------------------------------------------------------
// vec4_normalise_or_zero
// Safe normalization of a four-component Q1.15 vector.
// ----------------------------------------------------------------------------
// The block takes one vector per cycle while its input side is not held, and
// returns one result per vector, in order. Two front stages square, sum and
// test the length against the threshold, the queue registers each vector,
// an entry stage loads the search, and fifteen search stages settle one
// quotient bit each, the last of them serving as the output register.
// Vectors whose squared length is not above the threshold come out as zero
// with too_short set. With the result channel always ready, throughput is
// one vector per cycle; a stall on the result side fills the four-entry
// queue before the input side is held.
module vec4_normalise_or_zero (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [vnz_pkg::SumBits-1:0]  cfg_wdata,
  vnz_in_if.sink                       in_ch,
  vnz_out_if.source                    out_ch
);
  import vnz_pkg::*;

  comp_t [Lanes-1:0] in_comp;
  comp_t [Lanes-1:0] res_unit;
  vnz_item_t         f_item, q_item;
  logic              f_valid, f_ready, q_valid, q_ready;

  assign in_comp[0] = in_ch.comp_x;
  assign in_comp[1] = in_ch.comp_y;
  assign in_comp[2] = in_ch.comp_z;
  assign in_comp[3] = in_ch.comp_w;

  vnz_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_comp    (in_comp),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  vnz_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  vnz_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res_unit   (res_unit),
    .res_short  (out_ch.too_short)
  );

  assign out_ch.unit_x = res_unit[0];
  assign out_ch.unit_y = res_unit[1];
  assign out_ch.unit_z = res_unit[2];
  assign out_ch.unit_w = res_unit[3];
endmodule

// ===== verif/vnz_score.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnz_score
// Watches both channels of the normalizer, predicts each result from the
// accepted input beat and the current threshold, and counts mismatches.
// ----------------------------------------------------------------------------
module vnz_score (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [vnz_pkg::SumBits-1:0] cfg_wdata,
  vnz_in_if.sink                      in_mon,
  vnz_out_if.sink                     out_mon,
  output int                          fail_count,
  output int                          pending_count,
  output int                          short_seen,
  output int                          unit_seen
);
  import vnz_pkg::*;

  typedef struct packed {
    comp_t ux;
    comp_t uy;
    comp_t uz;
    comp_t uw;
    logic  short_flag;
  } unit_vec_t;

  logic [SumBits-1:0] threshold;
  unit_vec_t          unit_queue[$];

  // Largest q below 2^15 with (2q-1)^2 * S <= 4 * mag^2 * 2^30.
  function automatic logic [15:0] round_quotient(logic [16:0] mag, logic [127:0] s);
    logic [127:0] bound;
    logic [127:0] odd;
    logic [15:0]  q;
    logic [15:0]  t;
    bound = (128'(mag) * 128'(mag)) << 32;
    q = '0;
    for (int b = 14; b >= 0; b--) begin
      t = q | (16'd1 << b);
      odd = 128'(2 * t - 1);
      if (odd * odd * s <= bound) q = t;
    end
    return q;
  endfunction

  function automatic unit_vec_t normalise(comp_t x, comp_t y, comp_t z, comp_t w,
                                          logic [SumBits-1:0] thr);
    comp_t        c[4];
    logic [16:0]  mag[4];
    logic [127:0] s;
    logic [15:0]  q;
    comp_t        r[4];
    unit_vec_t    res;
    c[0] = x; c[1] = y; c[2] = z; c[3] = w;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = c[i][15] ? 17'(-$signed({c[i][15], c[i]})) : 17'(c[i]);
      s += 128'(mag[i]) * 128'(mag[i]);
    end
    if (s <= 128'(thr)) begin
      res = '0;
      res.short_flag = 1'b1;
      return res;
    end
    for (int i = 0; i < 4; i++) begin
      q = round_quotient(mag[i], s);
      r[i] = c[i][15] ? comp_t'(-q) : comp_t'(q);
    end
    res.ux = r[0]; res.uy = r[1]; res.uz = r[2]; res.uw = r[3];
    res.short_flag = 1'b0;
    return res;
  endfunction

  assign pending_count = unit_queue.size();

  always @(posedge clk) begin
    unit_vec_t want;
    unit_vec_t got;
    if (!rst_n) begin
      threshold <= SumBits'(10);
      fail_count <= 0;
      short_seen <= 0;
      unit_seen <= 0;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        unit_queue.push_back(normalise(in_mon.comp_x, in_mon.comp_y, in_mon.comp_z,
                                       in_mon.comp_w, threshold));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.unit_x, out_mon.unit_y, out_mon.unit_z, out_mon.unit_w,
                out_mon.too_short};
        if (unit_queue.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = unit_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d s=%b",
                     $time, want.ux, want.uy, want.uz, want.uw, want.short_flag);
            $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d s=%b",
                     $time, got.ux, got.uy, got.uz, got.uw, got.short_flag);
            fail_count <= fail_count + 1;
          end
          if (want.short_flag) short_seen <= short_seen + 1;
          else unit_seen <= unit_seen + 1;
        end
      end
    end
  end
endmodule

// ===== verif/vec4_normalise_or_zero_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_normalise_or_zero_test
// Drives directed and random vectors through the normalizer under several
// thresholds with random stalls on both channels; the checker judges results.
// ----------------------------------------------------------------------------
module vec4_normalise_or_zero_test;
  import vnz_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [SumBits-1:0] cfg_wdata = '0;
  logic               hold_off = 1'b0;
  int                 fail_count;
  int                 pending_count;
  int                 short_seen;
  int                 unit_seen;
  int                 sent = 0;

  vnz_in_if  in_ch();
  vnz_out_if out_ch();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.comp_x = '0; in_ch.comp_y = '0; in_ch.comp_z = '0; in_ch.comp_w = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vec4_normalise_or_zero DUT (.clk, .rst_n, .cfg_we, .cfg_wdata, .in_ch, .out_ch);

  vnz_score checker_i (.clk, .rst_n, .cfg_we, .cfg_wdata, .in_mon(in_ch),
    .out_mon(out_ch), .fail_count, .pending_count, .short_seen, .unit_seen);

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Result side: random ready, with a long hold-off whenever requested.
  initial begin
    int idle;
    @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        idle = gap_len();
        if (idle > 0) begin
          out_ch.ready <= 1'b0;
          repeat (idle) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_vec(comp_t x, comp_t y, comp_t z, comp_t w, bit gaps);
    int idle;
    if (gaps && $urandom_range(0, 3) == 0) begin
      idle = gap_len();
      if (idle > 0) begin
        in_ch.valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.comp_x <= x; in_ch.comp_y <= y; in_ch.comp_z <= z; in_ch.comp_w <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_threshold(logic [SumBits-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic comp_t rand_comp(int scale);
    case (scale)
      0: return comp_t'($urandom_range(0, 65535));
      1: return comp_t'($signed(5'($urandom_range(0, 31))));
      default: return comp_t'($urandom_range(0, 3) == 0 ? 16'h8000 :
                              $urandom_range(0, 1) ? 16'h7FFF : 16'h0000);
    endcase
  endfunction

  task automatic random_phase(int count);
    int sc;
    for (int i = 0; i < count; i++) begin
      sc = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
      send_vec(rand_comp(sc), rand_comp(sc), rand_comp(sc), rand_comp(sc), 1'b1);
    end
  endtask

  initial begin
    logic [SumBits-1:0] thresholds[5];
    thresholds = '{33'd0, 33'd1000, 33'h0_4000_0000, 33'h1_0000_0000, 33'h1_FFFF_FFFF};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: zero vector, default threshold edges, extremes and full scale.
    send_vec(0, 0, 0, 0, 1'b0);
    send_vec(3, 1, 0, 0, 1'b0);
    send_vec(3, 1, 1, 0, 1'b0);
    send_vec(-32768, 0, 0, 0, 1'b0);
    send_vec(32767, 0, 0, 0, 1'b0);
    send_vec(-32768, -32768, -32768, -32768, 1'b0);
    send_vec(32767, 32767, 32767, 32767, 1'b0);
    send_vec(-32768, 32767, -1, 1, 1'b0);
    send_vec(1, -1, 1, -1, 1'b0);
    send_vec(0, 0, 0, -4, 1'b0);
    send_vec(100, -200, 300, -400, 1'b0);
    send_vec(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 1'b0);
    drain();
    // The sender keeps offering while the receiver is held off.
    hold_off <= 1'b1;
    random_phase(40);
    drain();
    foreach (thresholds[k]) begin
      write_threshold(thresholds[k]);
      send_vec(-32768, -32768, -32768, -32768, 1'b0);
      send_vec(1, 0, 0, 0, 1'b0);
      random_phase(40);
      drain();
    end
    write_threshold(33'd10);
    random_phase(1550);
    drain();
    $display("Sent %0d vectors over six thresholds: %0d normalized, %0d too short.",
             sent, unit_seen, short_seen);
    if (fail_count == 0) begin
      $display("vec4_normalise_or_zero_test: clean");
    end else begin
      $display("vec4_normalise_or_zero_test: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("vec4_normalise_or_zero_test: errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/vnz_pkg.sv
hw/rtl/vnz_in_if.sv
hw/rtl/vnz_out_if.sv
hw/rtl/vnz_front.sv
hw/rtl/vnz_queue.sv
hw/rtl/vnz_back.sv
hw/rtl/vec4_normalise_or_zero.sv
verif/vnz_score.sv
verif/vec4_normalise_or_zero_test.sv
